@@ hw/rtl/aging_page_replacement_defines.svh @@
// assertion macros used by apr_checker.sv
`ifndef AGING_PAGE_REPLACEMENT_DEFINES_SVH
`define AGING_PAGE_REPLACEMENT_DEFINES_SVH

// condition in this cycle implies consequence in the next cycle
`define APR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apr check failed");

// condition implies consequence in the same cycle
`define APR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apr check failed");

`endif

@@ hw/rtl/apr_pkg.sv @@
package apr_pkg;

  // default sizes of the table
  localparam int FRAMES_DEF    = 128;
  localparam int AGE_BITS_DEF  = 64;
  localparam int PAGE_BITS_DEF = 16;

  // fixed port widths
  localparam int PAGE_NUMBER_W = 16;
  localparam int FRAME_INDEX_W = 7;
  localparam int LIMIT_W       = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;

  // operation codes
  localparam logic OP_REFERENCE = 1'b0;
  localparam logic OP_TICK      = 1'b1;

  // compare flags from the scan unit
  typedef struct packed {
    logic match;
    logic younger;
  } apr_cmp_t;

endpackage

@@ hw/rtl/apr_frame_mem.sv @@
module apr_frame_mem #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7,
  parameter int WIDTH  = 81
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/apr_scan_unit.sv @@
module apr_scan_unit #(
  parameter int AGE_BITS  = 64,
  parameter int PAGE_BITS = 16
) (
  input  logic                 entry_ref,
  input  logic [AGE_BITS-1:0]  entry_age,
  input  logic [PAGE_BITS-1:0] entry_page,
  input  logic [PAGE_BITS-1:0] key,
  input  logic [AGE_BITS-1:0]  best_age,
  output apr_pkg::apr_cmp_t    cmp,
  output logic [AGE_BITS-1:0]  aged
);
  import apr_pkg::*;

  // page match and age compare against the running minimum
  always_comb begin
    cmp.match   = (entry_page == key);
    cmp.younger = (entry_age < best_age);
  end

  // aging shift: referenced bit enters the top
  assign aged = {entry_ref, entry_age[AGE_BITS-1:1]};

endmodule

@@ hw/rtl/aging_page_replacement.sv @@
// flow: an accepted item is scanned against every filled frame, then its result is registered
// once the output is free; no new item is taken until that result is registered (in_ready only in idle)
// the frame scan makes one memory read per cycle; a result stall holds the block in the finish state
// reset: synchronous, clears control state, empties the table, limit 128
// frame memory contents are not cleared; only filled frames are ever read
module aging_page_replacement #(
  parameter int FRAMES    = apr_pkg::FRAMES_DEF,
  parameter int AGE_BITS  = apr_pkg::AGE_BITS_DEF,
  parameter int PAGE_BITS = apr_pkg::PAGE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [apr_pkg::LIMIT_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               operation,
  input  logic [apr_pkg::PAGE_NUMBER_W-1:0]  page_number,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               fault,
  output logic [apr_pkg::FRAME_INDEX_W-1:0]  frame_index,
  output logic                               evicted,
  output logic [apr_pkg::PAGE_NUMBER_W-1:0]  evicted_page
);
  import apr_pkg::*;

  localparam int IDX_W = $clog2(FRAMES);
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int ENT_W = 1 + AGE_BITS + PAGE_BITS;
  localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]           state;
  logic [LIMIT_W-1:0]   frame_limit;
  logic [CNT_W-1:0]     frames_used;
  logic                 op;
  logic [PAGE_BITS-1:0] page_key;
  logic [CNT_W-1:0]     rd_idx;
  logic                 dv;
  logic [IDX_W-1:0]     dv_idx;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic [IDX_W-1:0]     best_idx;
  logic [AGE_BITS-1:0]  best_age;
  logic [PAGE_BITS-1:0] best_page;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [ENT_W-1:0]     mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  logic [ENT_W-1:0]     rd_data;
  logic                 rd_ref;
  logic [AGE_BITS-1:0]  rd_age;
  logic [PAGE_BITS-1:0] rd_page;
  apr_cmp_t             cmp;
  logic [AGE_BITS-1:0]  aged;

  logic [CNT_W-1:0]     lim_eff;
  logic                 issue;
  logic                 install_free;
  logic [IDX_W-1:0]     inst_idx;
  logic                 out_free;

  assign rd_ref  = rd_data[ENT_W-1];
  assign rd_age  = rd_data[ENT_W-2:PAGE_BITS];
  assign rd_page = rd_data[PAGE_BITS-1:0];

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // frame store: page, age and referenced bit in one entry
  apr_frame_mem #(
    .DEPTH  (FRAMES),
    .ADDR_W (IDX_W),
    .WIDTH  (ENT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // shared compare and shift unit
  apr_scan_unit #(
    .AGE_BITS  (AGE_BITS),
    .PAGE_BITS (PAGE_BITS)
  ) u_scan (
    .entry_ref  (rd_ref),
    .entry_age  (rd_age),
    .entry_page (rd_page),
    .key        (page_key),
    .best_age   (best_age),
    .cmp        (cmp),
    .aged       (aged)
  );

  // limit clamped to one through FRAMES
  always_comb begin
    if (frame_limit == '0) begin
      lim_eff = CNT_W'(1);
    end else if (32'(frame_limit) > 32'(FRAMES)) begin
      lim_eff = CNT_W'(FRAMES);
    end else begin
      lim_eff = CNT_W'(frame_limit);
    end
  end

  // memory port control
  always_comb begin
    issue        = (state == S_SCAN) && (rd_idx < frames_used);
    install_free = (frames_used < lim_eff);
    inst_idx     = install_free ? frames_used[IDX_W-1:0] : best_idx;
    mem_raddr    = rd_idx[IDX_W-1:0];
    mem_we       = 1'b0;
    mem_waddr    = dv_idx;
    mem_wdata    = rd_data;
    if (state == S_SCAN && dv) begin
      if (op == OP_TICK) begin
        mem_we    = 1'b1;
        mem_wdata = {1'b0, aged, rd_page};
      end else if (cmp.match) begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, rd_age, rd_page};
      end
    end else if (state == S_FINISH && out_free && op == OP_REFERENCE && !hit) begin
      mem_we    = 1'b1;
      mem_waddr = inst_idx;
      mem_wdata = {1'b1, AGE_TOP, page_key};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frame_limit <= LIMIT_RESET;
      frames_used <= '0;
      out_valid   <= 1'b0;
      dv          <= 1'b0;
      hit         <= 1'b0;
    end else begin
      if (cfg_write) begin
        frame_limit <= cfg_data;
      end
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op       <= operation;
            page_key <= PAGE_BITS'(page_number);
            rd_idx   <= '0;
            dv       <= 1'b0;
            hit      <= 1'b0;
            hit_idx  <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          dv     <= issue;
          dv_idx <= rd_idx[IDX_W-1:0];
          if (issue) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          // first hit and lowest-indexed minimum age
          if (dv && op == OP_REFERENCE) begin
            if (cmp.match && !hit) begin
              hit     <= 1'b1;
              hit_idx <= dv_idx;
            end
            if (dv_idx == '0 || cmp.younger) begin
              best_idx  <= dv_idx;
              best_age  <= rd_age;
              best_page <= rd_page;
            end
          end
          if (!issue && !dv) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (op == OP_TICK) begin
              fault        <= 1'b0;
              frame_index  <= '0;
              evicted      <= 1'b0;
              evicted_page <= '0;
            end else if (hit) begin
              fault        <= 1'b0;
              frame_index  <= FRAME_INDEX_W'(hit_idx);
              evicted      <= 1'b0;
              evicted_page <= '0;
            end else if (install_free) begin
              fault        <= 1'b1;
              frame_index  <= FRAME_INDEX_W'(frames_used);
              evicted      <= 1'b0;
              evicted_page <= '0;
              frames_used  <= frames_used + CNT_W'(1);
            end else begin
              fault        <= 1'b1;
              frame_index  <= FRAME_INDEX_W'(best_idx);
              evicted      <= 1'b1;
              evicted_page <= PAGE_NUMBER_W'(best_page);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/apr_checker.sv @@
`include "aging_page_replacement_defines.svh"

module apr_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cfg_write,
  input logic [apr_pkg::LIMIT_W-1:0]        cfg_data,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               operation,
  input logic [apr_pkg::PAGE_NUMBER_W-1:0]  page_number,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               fault,
  input logic [apr_pkg::FRAME_INDEX_W-1:0]  frame_index,
  input logic                               evicted,
  input logic [apr_pkg::PAGE_NUMBER_W-1:0]  evicted_page
);
  import apr_pkg::*;

  // a stalled result beat holds
  `APR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({fault, frame_index, evicted, evicted_page}))

  // the block is busy scanning right after taking a beat
  `APR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // an eviction only happens on a fault
  `APR_ASSERT_SAME(a_evict_needs_fault, out_valid && evicted, fault)

  // hits and ticks never report a replaced page
  `APR_ASSERT_SAME(a_no_evict_on_hit, out_valid && !fault, !evicted && evicted_page == '0)

endmodule

bind aging_page_replacement apr_checker u_apr_checker (.*);
